### src/lccd_pkg.sv
package lccd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TICK_BITS   = 32;
    localparam int SUM_BITS    = 24;
    localparam int IDX_BITS    = 12;
    localparam int FRAME_BITS  = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 25;

    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRATION = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GATE_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_WIDTH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUMMIES     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALID       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTINUOUS  = 3'd6;

    typedef struct packed {
        logic [24:0]         integration_ticks;
        logic [15:0]         gate_to_shift_ticks;
        logic [15:0]         shift_width_ticks;
        logic [IDX_BITS-1:0] total_samples;
        logic [IDX_BITS-1:0] leading_dummies;
        logic [IDX_BITS-1:0] valid_pixels;
        logic                continuous;
    } t_cfg;

    typedef struct packed {
        logic                   gate_level;
        logic                   shift_level;
        logic                   readout_active;
        logic                   pixel_valid;
        logic [IDX_BITS-1:0]    pixel_pos;
        logic [SAMPLE_BITS-1:0] pixel_value;
        logic                   frame_done;
        logic                   frame_ok;
        logic [FRAME_BITS-1:0]  frame_number;
        logic [SUM_BITS-1:0]    pixel_sum;
        logic [SAMPLE_BITS-1:0] pixel_min;
        logic [SAMPLE_BITS-1:0] pixel_max;
    } t_result;

endpackage

### src/lccd_cfg.sv
module lccd_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [lccd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [lccd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output lccd_pkg::t_cfg                       o_cfg
);

    lccd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.integration_ticks   <= 25'd20000;
            r_cfg.gate_to_shift_ticks <= 16'd1;
            r_cfg.shift_width_ticks   <= 16'd2;
            r_cfg.total_samples       <= 12'd3694;
            r_cfg.leading_dummies     <= 12'd32;
            r_cfg.valid_pixels        <= 12'd3648;
            r_cfg.continuous          <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lccd_pkg::REG_INTEGRATION: r_cfg.integration_ticks   <= i_cfg_data;
                lccd_pkg::REG_GATE_SHIFT:  r_cfg.gate_to_shift_ticks <= i_cfg_data[15:0];
                lccd_pkg::REG_SHIFT_WIDTH: r_cfg.shift_width_ticks   <= i_cfg_data[15:0];
                lccd_pkg::REG_TOTAL:       r_cfg.total_samples       <= i_cfg_data[11:0];
                lccd_pkg::REG_DUMMIES:     r_cfg.leading_dummies     <= i_cfg_data[11:0];
                lccd_pkg::REG_VALID:       r_cfg.valid_pixels        <= i_cfg_data[11:0];
                lccd_pkg::REG_CONTINUOUS:  r_cfg.continuous          <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/lccd_core.sv
module lccd_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [1:0]                          i_func,
    input  logic [lccd_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  lccd_pkg::t_cfg                      i_cfg,
    output lccd_pkg::t_result                   o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INTEGRATE,
        PH_DELAY,
        PH_SHIFT,
        PH_READOUT
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [lccd_pkg::TICK_BITS-1:0]      r_ticks, n_ticks, w_ticks_inc;
    logic                                r_gate, n_gate, r_shift, n_shift;
    logic [lccd_pkg::IDX_BITS-1:0]       r_seen, n_seen, r_stored, n_stored;
    logic [lccd_pkg::FRAME_BITS-1:0]     r_frames, n_frames;
    logic [lccd_pkg::SUM_BITS-1:0]       r_sum, n_sum;
    logic [lccd_pkg::SUM_BITS:0]         w_sum_wide;
    logic [lccd_pkg::SAMPLE_BITS-1:0]    r_min, n_min, r_max, n_max;
    logic [lccd_pkg::TICK_BITS-1:0]      w_int_lim, w_g2s_lim, w_sw_lim;
    logic                                w_pv, w_done, w_ok;

    always_comb begin
        w_ticks_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
        w_int_lim = (i_cfg.integration_ticks == '0) ? lccd_pkg::TICK_BITS'(1)
                  : lccd_pkg::TICK_BITS'(i_cfg.integration_ticks);
        w_g2s_lim = lccd_pkg::TICK_BITS'(i_cfg.gate_to_shift_ticks);
        w_sw_lim  = (i_cfg.shift_width_ticks == '0) ? lccd_pkg::TICK_BITS'(1)
                  : lccd_pkg::TICK_BITS'(i_cfg.shift_width_ticks);
        w_sum_wide = {1'b0, r_sum}
                   + (lccd_pkg::SUM_BITS + 1)'(i_sample);

        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_gate   = r_gate;
        n_shift  = r_shift;
        n_seen   = r_seen;
        n_stored = r_stored;
        n_frames = r_frames;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        w_pv     = 1'b0;
        w_done   = 1'b0;
        w_ok     = 1'b0;

        case (i_func)
            lccd_pkg::FUNC_START: begin
                if (r_phase == PH_IDLE) begin
                    n_gate  = 1'b0;
                    n_shift = 1'b0;
                    n_phase = PH_INTEGRATE;
                    n_ticks = '0;
                end
            end
            lccd_pkg::FUNC_TICK: begin
                case (r_phase)
                    PH_INTEGRATE: begin
                        n_ticks = w_ticks_inc;
                        if (w_ticks_inc >= w_int_lim) begin
                            n_gate  = 1'b1;
                            n_phase = PH_DELAY;
                            n_ticks = '0;
                            if (i_cfg.gate_to_shift_ticks == '0) begin
                                n_shift = 1'b1;
                                n_phase = PH_SHIFT;
                            end
                        end
                    end
                    PH_DELAY: begin
                        n_ticks = w_ticks_inc;
                        if (w_ticks_inc >= w_g2s_lim) begin
                            n_shift = 1'b1;
                            n_phase = PH_SHIFT;
                            n_ticks = '0;
                        end
                    end
                    PH_SHIFT: begin
                        n_ticks = w_ticks_inc;
                        if (w_ticks_inc >= w_sw_lim) begin
                            n_shift  = 1'b0;
                            n_phase  = PH_READOUT;
                            n_ticks  = '0;
                            n_seen   = '0;
                            n_stored = '0;
                            n_sum    = '0;
                            n_min    = '1;
                            n_max    = '0;
                        end
                    end
                    default: ;
                endcase
            end
            lccd_pkg::FUNC_SAMPLE: begin
                if (r_phase == PH_READOUT) begin
                    if (r_seen >= i_cfg.leading_dummies && r_stored < i_cfg.valid_pixels) begin
                        w_pv     = 1'b1;
                        n_sum    = w_sum_wide[lccd_pkg::SUM_BITS] ? '1
                                 : w_sum_wide[lccd_pkg::SUM_BITS-1:0];
                        n_min    = (i_sample < r_min) ? i_sample : r_min;
                        n_max    = (i_sample > r_max) ? i_sample : r_max;
                        n_stored = r_stored + 1'b1;
                    end
                    n_seen = r_seen + 1'b1;
                    if (n_seen >= i_cfg.total_samples) begin
                        w_done   = 1'b1;
                        w_ok     = (n_stored >= i_cfg.valid_pixels);
                        n_frames = r_frames + 1'b1;
                        n_ticks  = '0;
                        if (i_cfg.continuous) begin
                            n_gate  = 1'b0;
                            n_shift = 1'b0;
                            n_phase = PH_INTEGRATE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase

        o_result.gate_level     = n_gate;
        o_result.shift_level    = n_shift;
        o_result.readout_active = (n_phase == PH_READOUT);
        o_result.pixel_valid    = w_pv;
        o_result.pixel_pos      = w_pv ? r_stored : '0;
        o_result.pixel_value    = w_pv ? i_sample : '0;
        o_result.frame_done     = w_done;
        o_result.frame_ok       = w_ok;
        o_result.frame_number   = n_frames;
        o_result.pixel_sum      = n_sum;
        o_result.pixel_min      = n_min;
        o_result.pixel_max      = n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ticks  <= '0;
            r_gate   <= 1'b0;
            r_shift  <= 1'b0;
            r_seen   <= '0;
            r_stored <= '0;
            r_frames <= '0;
            r_sum    <= '0;
            r_min    <= '1;
            r_max    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_ticks  <= n_ticks;
            r_gate   <= n_gate;
            r_shift  <= n_shift;
            r_seen   <= n_seen;
            r_stored <= n_stored;
            r_frames <= n_frames;
            r_sum    <= n_sum;
            r_min    <= n_min;
            r_max    <= n_max;
        end
    end

endmodule

### src/linear_ccd_timing_and_readout.sv
// channel   direction  handshake                  payload
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
// item      in         i_valid / o_ready           i_func, i_sample
// result    out        o_valid / i_ready           o_gate_level .. o_pixel_max
//
// one item per cycle while no result is stalled; its result is in the output register in the cycle after the transfer
// the result is computed combinationally from the sequencer state and held in the output register
// synchronous active-low reset returns to idle with the register reset values
// a stalled result holds; a new item is taken in the cycle the held result is taken
module linear_ccd_timing_and_readout (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lccd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [lccd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_func,
    input  logic [lccd_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_gate_level,
    output logic                                 o_shift_level,
    output logic                                 o_readout_active,
    output logic                                 o_pixel_valid,
    output logic [lccd_pkg::IDX_BITS-1:0]        o_pixel_pos,
    output logic [lccd_pkg::SAMPLE_BITS-1:0]     o_pixel_value,
    output logic                                 o_frame_done,
    output logic                                 o_frame_ok,
    output logic [lccd_pkg::FRAME_BITS-1:0]      o_frame_number,
    output logic [lccd_pkg::SUM_BITS-1:0]        o_pixel_sum,
    output logic [lccd_pkg::SAMPLE_BITS-1:0]     o_pixel_min,
    output logic [lccd_pkg::SAMPLE_BITS-1:0]     o_pixel_max
);

    lccd_pkg::t_cfg    w_cfg;
    lccd_pkg::t_result w_result;
    lccd_pkg::t_result r_out;
    logic              r_valid;
    logic              w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_valid || i_ready;
    assign w_accept    = i_valid && o_ready;

    lccd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lccd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_func   (i_func),
        .i_sample (i_sample),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_valid;
    assign o_gate_level     = r_out.gate_level;
    assign o_shift_level    = r_out.shift_level;
    assign o_readout_active = r_out.readout_active;
    assign o_pixel_valid    = r_out.pixel_valid;
    assign o_pixel_pos      = r_out.pixel_pos;
    assign o_pixel_value    = r_out.pixel_value;
    assign o_frame_done     = r_out.frame_done;
    assign o_frame_ok       = r_out.frame_ok;
    assign o_frame_number   = r_out.frame_number;
    assign o_pixel_sum      = r_out.pixel_sum;
    assign o_pixel_min      = r_out.pixel_min;
    assign o_pixel_max      = r_out.pixel_max;

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lccd_pkg::*;

    localparam logic [1:0]              FUNC_NOP       = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED     = 3'd7;
    localparam int unsigned             WATCHDOG_LIMIT = 5000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_INTEGRATE,
        SEQ_DELAY,
        SEQ_SHIFT,
        SEQ_READOUT
    } t_seq_phase;

    typedef struct packed {
        logic [1:0]             func;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   drain_first;
    } t_cmd;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_func = FUNC_NOP;
    logic [SAMPLE_BITS-1:0]   i_sample = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_gate_level;
    logic                     o_shift_level;
    logic                     o_readout_active;
    logic                     o_pixel_valid;
    logic [IDX_BITS-1:0]      o_pixel_pos;
    logic [SAMPLE_BITS-1:0]   o_pixel_value;
    logic                     o_frame_done;
    logic                     o_frame_ok;
    logic [FRAME_BITS-1:0]    o_frame_number;
    logic [SUM_BITS-1:0]      o_pixel_sum;
    logic [SAMPLE_BITS-1:0]   o_pixel_min;
    logic [SAMPLE_BITS-1:0]   o_pixel_max;

    linear_ccd_timing_and_readout uut (.*);

    // sequencer copy
    t_cfg                   m_cfg;
    t_seq_phase             m_phase;
    logic [TICK_BITS-1:0]   m_ticks;
    logic                   m_gate;
    logic                   m_shift;
    logic [IDX_BITS-1:0]    m_seen;
    logic [IDX_BITS-1:0]    m_stored;
    logic [FRAME_BITS-1:0]  m_frames;
    logic [SUM_BITS-1:0]    m_sum;
    logic [SAMPLE_BITS-1:0] m_min;
    logic [SAMPLE_BITS-1:0] m_max;

    t_cmd        command_q[$];
    t_result     expected_status_q[$];
    logic        results_drained = 1'b1;
    logic        quiet_mode = 1'b0;
    int unsigned queued_count = 0;
    int unsigned error_count = 0;
    int unsigned send_gap = 0;
    int unsigned ready_gap = 0;
    int unsigned stall_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] min_one(logic [31:0] v);
        return (v == 0) ? 32'd1 : v;
    endfunction

    function automatic void begin_integration();
        m_gate = 1'b0;
        m_shift = 1'b0;
        m_phase = SEQ_INTEGRATE;
        m_ticks = '0;
    endfunction

    function automatic void raise_shift();
        m_shift = 1'b1;
        m_phase = SEQ_SHIFT;
        m_ticks = '0;
    endfunction

    function automatic void count_tick();
        if (m_ticks != '1) begin
            m_ticks = m_ticks + 1'b1;
        end
    endfunction

    function automatic t_result ccd_step(logic [1:0] func, logic [SAMPLE_BITS-1:0] smp);
        t_result           r;
        logic [SUM_BITS:0] sum_next;
        r = '0;
        case (func)
            FUNC_START: begin
                if (m_phase == SEQ_IDLE) begin_integration();
            end
            FUNC_TICK: begin
                case (m_phase)
                    SEQ_INTEGRATE: begin
                        count_tick();
                        if (m_ticks >= min_one(32'(m_cfg.integration_ticks))) begin
                            m_gate = 1'b1;
                            m_phase = SEQ_DELAY;
                            m_ticks = '0;
                            if (m_cfg.gate_to_shift_ticks == '0) raise_shift();
                        end
                    end
                    SEQ_DELAY: begin
                        count_tick();
                        if (m_ticks >= 32'(m_cfg.gate_to_shift_ticks)) raise_shift();
                    end
                    SEQ_SHIFT: begin
                        count_tick();
                        if (m_ticks >= min_one(32'(m_cfg.shift_width_ticks))) begin
                            m_shift = 1'b0;
                            m_phase = SEQ_READOUT;
                            m_ticks = '0;
                            m_seen = '0;
                            m_stored = '0;
                            m_sum = '0;
                            m_min = '1;
                            m_max = '0;
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_SAMPLE: begin
                if (m_phase == SEQ_READOUT) begin
                    if (m_seen >= m_cfg.leading_dummies && m_stored < m_cfg.valid_pixels) begin
                        r.pixel_valid = 1'b1;
                        r.pixel_pos = m_stored;
                        r.pixel_value = smp;
                        sum_next = m_sum + smp;
                        m_sum = sum_next[SUM_BITS] ? '1 : sum_next[SUM_BITS-1:0];
                        if (smp < m_min) m_min = smp;
                        if (smp > m_max) m_max = smp;
                        m_stored = m_stored + 1'b1;
                    end
                    m_seen = m_seen + 1'b1;
                    if (m_seen >= m_cfg.total_samples) begin
                        r.frame_done = 1'b1;
                        r.frame_ok = (m_stored >= m_cfg.valid_pixels);
                        m_frames = m_frames + 1'b1;
                        if (m_cfg.continuous) begin
                            begin_integration();
                        end else begin
                            m_phase = SEQ_IDLE;
                            m_ticks = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.gate_level = m_gate;
        r.shift_level = m_shift;
        r.readout_active = (m_phase == SEQ_READOUT);
        r.frame_number = m_frames;
        r.pixel_sum = m_sum;
        r.pixel_min = m_min;
        r.pixel_max = m_max;
        return r;
    endfunction

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (error_count < 10) begin
                $display("mismatch %s: expected %0h got %0h", name, want, got);
            end
            error_count++;
        end
    endtask

    // item side: pending commands go out with random gaps
    always @(posedge i_clk) begin : command_driver
        t_cmd nxt;
        logic took;
        took = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (took) begin
                expected_status_q.push_back(ccd_step(i_func, i_sample));
            end
            if (i_valid && !o_ready) begin
                // hold until the transfer
            end else if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (command_q.size() != 0 &&
                         !(command_q[0].drain_first && (took || !results_drained))) begin
                nxt = command_q.pop_front();
                i_valid <= 1'b1;
                i_func <= nxt.func;
                i_sample <= nxt.sample;
                send_gap <= quiet_mode ? 0 : idle_cycles();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        results_drained <= (expected_status_q.size() == 0);
    end

    // result side: compare each transfer against the oldest prediction
    always @(posedge i_clk) begin : status_monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_gate_level, o_shift_level, o_readout_active, o_pixel_valid,
                       o_pixel_pos, o_pixel_value, o_frame_done, o_frame_ok,
                       o_frame_number, o_pixel_sum, o_pixel_min, o_pixel_max};
                if (expected_status_q.size() == 0) begin
                    if (error_count < 10) $display("unexpected result transfer");
                    error_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("gate_level", want.gate_level, got.gate_level);
                    check_field("shift_level", want.shift_level, got.shift_level);
                    check_field("readout_active", want.readout_active, got.readout_active);
                    check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
                    check_field("pixel_pos", want.pixel_pos, got.pixel_pos);
                    check_field("pixel_value", want.pixel_value, got.pixel_value);
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("frame_ok", want.frame_ok, got.frame_ok);
                    check_field("frame_number", want.frame_number, got.frame_number);
                    check_field("pixel_sum", want.pixel_sum, got.pixel_sum);
                    check_field("pixel_min", want.pixel_min, got.pixel_min);
                    check_field("pixel_max", want.pixel_max, got.pixel_max);
                end
            end
            if (ready_gap != 0) begin
                i_ready <= 1'b0;
                ready_gap <= ready_gap - 1;
            end else begin
                i_ready <= 1'b1;
                if (!quiet_mode && $urandom_range(0, 3) == 0) ready_gap <= idle_cycles();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_cmd(logic [1:0] func, logic [SAMPLE_BITS-1:0] smp, logic pause = 1'b0);
        command_q.push_back({func, smp, pause});
        queued_count++;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (command_q.size() != 0 || expected_status_q.size() != 0 || i_valid);
    endtask

    // finish any frame in progress so the block is idle for register writes
    task automatic drain_to_idle();
        wait_drained();
        while (m_phase != SEQ_IDLE) begin
            if (m_phase == SEQ_READOUT) begin
                queue_cmd(FUNC_SAMPLE, rand_sample());
            end else begin
                queue_cmd(FUNC_TICK, rand_sample());
            end
            wait_drained();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        logic [CFG_DATA_BITS-1:0] junk;
        logic [CFG_DATA_BITS-1:0] data;
        int unsigned              w;
        case (idx)
            REG_INTEGRATION: w = 25;
            REG_GATE_SHIFT, REG_SHIFT_WIDTH: w = 16;
            REG_CONTINUOUS: w = 1;
            default: w = 12;
        endcase
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_BITS'($urandom) : '0;
        data = value | (junk << w);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_INTEGRATION: m_cfg.integration_ticks = data;
            REG_GATE_SHIFT: m_cfg.gate_to_shift_ticks = data[15:0];
            REG_SHIFT_WIDTH: m_cfg.shift_width_ticks = data[15:0];
            REG_TOTAL: m_cfg.total_samples = data[11:0];
            REG_DUMMIES: m_cfg.leading_dummies = data[11:0];
            REG_VALID: m_cfg.valid_pixels = data[11:0];
            REG_CONTINUOUS: m_cfg.continuous = data[0];
            default: ;
        endcase
    endtask

    task automatic load_config(int unsigned integ, int unsigned g2s, int unsigned sw,
                               int unsigned total, int unsigned dummies, int unsigned pixels,
                               int unsigned cont);
        write_reg(REG_INTEGRATION, integ);
        write_reg(REG_GATE_SHIFT, g2s);
        write_reg(REG_SHIFT_WIDTH, sw);
        write_reg(REG_TOTAL, total);
        write_reg(REG_DUMMIES, dummies);
        write_reg(REG_VALID, pixels);
        write_reg(REG_CONTINUOUS, cont);
        write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
        @(negedge i_clk);
    endtask

    task automatic load_random_config(int unsigned cont);
        int unsigned integ;
        int unsigned total;
        case ($urandom_range(0, 9))
            0: integ = 0;
            1: integ = 1;
            default: integ = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
            0: total = 0;
            1: total = $urandom_range(30, 60);
            default: total = $urandom_range(1, 16);
        endcase
        load_config(integ, $urandom_range(0, 4), $urandom_range(0, 3), total,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6),
                    $urandom_range(0, 16), cont);
    endtask

    // one capture: start, enough ticks to reach readout, then the samples,
    // with stray commands mixed in and now and then a cut-short sequence
    task automatic queue_frame(logic force_pause);
        int unsigned n_ticks;
        int unsigned n_samples;
        n_ticks = min_one(32'(m_cfg.integration_ticks)) + 32'(m_cfg.gate_to_shift_ticks)
                  + min_one(32'(m_cfg.shift_width_ticks)) + $urandom_range(0, 2);
        n_samples = min_one(32'(m_cfg.total_samples)) + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) n_ticks = $urandom_range(0, n_ticks);
        if ($urandom_range(0, 9) == 0) n_samples = $urandom_range(0, n_samples);
        queue_cmd(FUNC_START, rand_sample(), force_pause || ($urandom_range(0, 7) == 0));
        repeat (n_ticks) begin
            if ($urandom_range(0, 9) == 0) queue_cmd(2'($urandom_range(0, 3)), rand_sample());
            queue_cmd(FUNC_TICK, rand_sample());
        end
        repeat (n_samples) begin
            if ($urandom_range(0, 9) == 0) queue_cmd(2'($urandom_range(0, 3)), rand_sample());
            queue_cmd(FUNC_SAMPLE, rand_sample());
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        m_cfg.integration_ticks = 25'd20000;
        m_cfg.gate_to_shift_ticks = 16'd1;
        m_cfg.shift_width_ticks = 16'd2;
        m_cfg.total_samples = 12'd3694;
        m_cfg.leading_dummies = 12'd32;
        m_cfg.valid_pixels = 12'd3648;
        m_cfg.continuous = 1'b0;
        m_phase = SEQ_IDLE;
        m_ticks = '0;
        m_gate = 1'b0;
        m_shift = 1'b0;
        m_seen = '0;
        m_stored = '0;
        m_frames = '0;
        m_sum = '0;
        m_min = '1;
        m_max = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: ticks, samples and no-ops while idle
        queue_cmd(FUNC_SAMPLE, 12'hFFF);
        queue_cmd(FUNC_TICK, 12'h000);
        queue_cmd(FUNC_NOP, 12'hAAA);
        queue_cmd(FUNC_SAMPLE, 12'h000);
        drain_to_idle();

        // zero integration, delay and width; fewer pixels than asked for
        load_config(0, 0, 0, 3, 1, 5, 0);
        queue_cmd(FUNC_START, 12'h555);
        queue_cmd(FUNC_START, 12'hAAA);
        queue_cmd(FUNC_SAMPLE, 12'h555);
        queue_cmd(FUNC_NOP, 12'hFFF);
        queue_cmd(FUNC_TICK, 12'h000);
        queue_cmd(FUNC_TICK, 12'hFFF);
        queue_cmd(FUNC_TICK, 12'h123);
        queue_cmd(FUNC_START, 12'h000);
        queue_cmd(FUNC_SAMPLE, 12'hFFF);
        queue_cmd(FUNC_SAMPLE, 12'h000);
        queue_cmd(FUNC_SAMPLE, 12'hFFF);
        queue_cmd(FUNC_SAMPLE, 12'h800);
        queue_cmd(FUNC_TICK, 12'h001);
        drain_to_idle();

        // zero total samples and zero valid pixels
        load_config(2, 1, 1, 0, 0, 0, 0);
        queue_cmd(FUNC_START, 12'h000);
        repeat (4) queue_cmd(FUNC_TICK, 12'hFFF);
        queue_cmd(FUNC_SAMPLE, 12'hFFF);
        drain_to_idle();

        // one long frame, mostly full-scale samples
        quiet_mode = 1'b1;
        load_config(1, 5, 1, 120, 0, 120, 0);
        queue_cmd(FUNC_START, 12'h000);
        repeat (7) queue_cmd(FUNC_TICK, 12'h000);
        repeat (120) begin
            queue_cmd(FUNC_SAMPLE, ($urandom_range(0, 3) != 0) ? 12'hFFF : rand_sample());
        end
        drain_to_idle();

        // largest register values, no capture started
        quiet_mode = 1'b0;
        load_config(25'h1FFFFFF, 16'hFFFF, 16'hFFFF, 4095, 4095, 4095, 1);
        repeat (10) queue_cmd(2'($urandom_range(1, 3)), rand_sample());
        drain_to_idle();

        for (int p = 0; p < 5; p++) begin
            quiet_mode = (p % 3 == 0);
            load_random_config(0);
            target = queued_count + 80;
            queue_frame(p == 0);
            while (queued_count < target) queue_frame(1'b0);
            drain_to_idle();
        end

        // free-running capture last, since it never returns to idle
        quiet_mode = 1'b0;
        load_random_config(1);
        target = queued_count + 80;
        while (queued_count < target) queue_frame(1'b0);

        wait_drained();
        repeat (10) @(negedge i_clk);
        error_count += expected_status_q.size();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
